FILE: sv/bns_pkg.sv
// shared types and constants for the buzzer note sequencer
package bns_pkg;

    localparam int BNS_QUEUE_DEPTH = 64;

    localparam int FREQ_W = 16;
    localparam int MS_W   = 16;
    localparam int DUTY_W = 8;
    localparam int VOL_W  = 2;
    localparam int OP_W   = 2;

    localparam logic [DUTY_W-1:0] DUTY_OFF   = 8'd0;
    localparam logic [DUTY_W-1:0] DUTY_QUIET = 8'd40;
    localparam logic [DUTY_W-1:0] DUTY_LOUD  = 8'd128;
    localparam logic [MS_W-1:0]   ELAPSED_MAX = 16'hFFFF;

    localparam logic [VOL_W-1:0] VOL_QUIET = 2'd1;
    localparam logic [VOL_W-1:0] VOL_RESET = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq;
        logic [DUTY_W-1:0] duty;
        logic              busy_res;
        logic              sounding;
    } res_t;

endpackage

FILE: sv/bns_in_if.sv
// input channel: one operation with its note fields
interface bns_in_if;
    import bns_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [FREQ_W-1:0] note_freq;
    logic [MS_W-1:0]   note_ms;

    modport source (output valid, output operation, output note_freq, output note_ms,
                    input ready);
    modport sink   (input valid, input operation, input note_freq, input note_ms,
                    output ready);
endinterface

FILE: sv/bns_out_if.sv
// result channel: buzzer state after each operation
interface bns_out_if;
    import bns_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] tone_freq;
    logic [DUTY_W-1:0] duty;
    logic              busy_res;
    logic              sounding;

    modport source (output valid, output tone_freq, output duty, output busy_res,
                    output sounding, input ready);
    modport sink   (input valid, input tone_freq, input duty, input busy_res,
                    input sounding, output ready);
endinterface

FILE: sv/bns_cfg_if.sv
// configuration write channel for the volume level register
interface bns_cfg_if;
    import bns_pkg::*;

    logic             valid;
    logic             ready;
    logic [VOL_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/bns_note_store.sv
// note memory with one write port and one registered read port
module bns_note_store
    import bns_pkg::*;
#(
    parameter int QUEUE_DEPTH = BNS_QUEUE_DEPTH,
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic [FREQ_W+MS_W-1:0]   wr_data,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic [FREQ_W+MS_W-1:0]   rd_data
);

    logic [FREQ_W+MS_W-1:0] mem [QUEUE_DEPTH];
    logic [FREQ_W+MS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // forward a same-cycle write so the read word is never stale
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/bns_core.sv
// sequencer state and per-operation update logic
module bns_core
    import bns_pkg::*;
#(
    parameter int QUEUE_DEPTH = BNS_QUEUE_DEPTH,
    localparam int POS_W = $clog2(QUEUE_DEPTH + 1),
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_acc,
    input  logic [OP_W-1:0]        operation,
    input  logic [FREQ_W-1:0]      note_freq,
    input  logic [MS_W-1:0]        note_ms,
    input  logic                   vol_we,
    input  logic [VOL_W-1:0]       vol_data,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output logic [FREQ_W+MS_W-1:0] wr_data,
    output logic [IDX_W-1:0]       rd_addr,
    input  logic [FREQ_W+MS_W-1:0] rd_data,
    output res_t                   result
);

    logic [POS_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              active_reg, active_next;
    logic [MS_W-1:0]   elapsed_reg, elapsed_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [VOL_W-1:0]  vol_reg;

    logic [MS_W-1:0]   elapsed_inc;
    logic [MS_W-1:0]   entry_ms;
    logic [FREQ_W-1:0] entry_freq;
    logic [DUTY_W-1:0] level_duty;
    logic              full;
    logic [POS_W-1:0]  pos_adv;

    assign entry_freq  = rd_data[FREQ_W-1:0];
    assign entry_ms    = rd_data[FREQ_W+MS_W-1:FREQ_W];
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign level_duty  = (vol_reg == VOL_QUIET) ? DUTY_QUIET : DUTY_LOUD;
    assign full        = (len_reg == POS_W'(QUEUE_DEPTH));
    assign pos_adv     = pos_reg + POS_W'(1);

    always_comb
    begin
        len_next     = len_reg;
        pos_next     = pos_reg;
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        freq_next    = freq_reg;
        duty_next    = duty_reg;
        wr_en        = 1'b0;
        if (item_acc)
        begin
            unique case (operation)
                OP_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (pos_reg >= len_reg)
                    begin
                        // drained: close any slot still open
                        if (active_reg)
                        begin
                            duty_next   = DUTY_OFF;
                            active_next = 1'b0;
                        end
                    end
                    else if (!active_reg)
                    begin
                        // start the note at the play position, a rest keeps the tone
                        if (entry_freq != '0)
                        begin
                            freq_next = entry_freq;
                            duty_next = level_duty;
                        end
                        elapsed_next = '0;
                        active_next  = 1'b1;
                    end
                    else if (elapsed_inc >= entry_ms)
                    begin
                        pos_next  = pos_adv;
                        duty_next = DUTY_OFF;
                        // one-tick gap if notes remain, else stay open until next tick
                        if (pos_adv < len_reg)
                        begin
                            elapsed_next = '0;
                            active_next  = 1'b0;
                        end
                    end
                end
                OP_ADD:
                begin
                    if (!full)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + POS_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    len_next    = '0;
                    pos_next    = '0;
                    active_next = 1'b0;
                    duty_next   = DUTY_OFF;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign wr_addr = len_reg[IDX_W-1:0];
    assign wr_data = {note_ms, note_freq};
    assign rd_addr = pos_next[IDX_W-1:0];

    assign result.tone_freq = freq_next;
    assign result.duty      = duty_next;
    assign result.busy_res  = (pos_next < len_next);
    assign result.sounding  = active_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            pos_reg     <= '0;
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
            freq_reg    <= '0;
            duty_reg    <= DUTY_OFF;
            vol_reg     <= VOL_RESET;
        end
        else
        begin
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            freq_reg    <= freq_next;
            duty_reg    <= duty_next;
            if (vol_we)
            begin
                vol_reg <= vol_data;
            end
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= len_reg)
        else $error("play position beyond queue length");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= POS_W'(QUEUE_DEPTH))
        else $error("queue length beyond depth");

    a_duty_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_reg != DUTY_OFF) |-> active_reg)
        else $error("buzzer driven with no active slot");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && operation == OP_CLEAR) |=> (len_reg == '0 && !active_reg))
        else $error("clear did not empty the queue");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("write into a full queue");

endmodule

FILE: sv/buzzer_note_sequencer.sv
// buzzer note sequencer: takes one operation per cycle unless a result waits unread
// latency: result valid on the cycle after the input transfer, held in an output register
// throughput: one operation per cycle; input stalls only while a result waits unread
// the note memory read port is registered and tracks the next play position
// reset clears queue length, play position, slot, counters and duty; volume resets to loud
// note memory contents stay undefined after reset and are only read once written
module buzzer_note_sequencer
    import bns_pkg::*;
#(
    parameter int QUEUE_DEPTH = BNS_QUEUE_DEPTH
)
(
    input logic       clk,
    input logic       rst_n,
    bns_in_if.sink    note_in,
    bns_out_if.source note_out,
    bns_cfg_if.sink   cfg
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic                   in_ready;
    logic                   item_acc;
    logic                   out_valid_reg;
    res_t                   res_reg;
    res_t                   res_post;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [FREQ_W+MS_W-1:0] wr_data;
    logic [IDX_W-1:0]       rd_addr;
    logic [FREQ_W+MS_W-1:0] rd_data;

    // output register frees up on the same cycle it is read
    assign in_ready      = !out_valid_reg || note_out.ready;
    assign item_acc      = note_in.valid && in_ready;
    assign note_in.ready = in_ready;
    assign cfg.ready     = 1'b1;

    bns_note_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bns_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_acc  (item_acc),
        .operation (note_in.operation),
        .note_freq (note_in.note_freq),
        .note_ms   (note_in.note_ms),
        .vol_we    (cfg.valid),
        .vol_data  (cfg.data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .result    (res_post)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= note_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            res_reg <= res_post;
        end
    end

    assign note_out.valid     = out_valid_reg;
    assign note_out.tone_freq = res_reg.tone_freq;
    assign note_out.duty      = res_reg.duty;
    assign note_out.busy_res  = res_reg.busy_res;
    assign note_out.sounding  = res_reg.sounding;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> note_in.ready)
        else $error("input stalled with empty output register");

    a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> out_valid_reg)
        else $error("accepted operation produced no result");

    a_no_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!note_in.valid && (!out_valid_reg || note_out.ready)) |=> !out_valid_reg)
        else $error("result appeared with no input transfer");

endmodule

FILE: tb/tb.sv
// self-checking testbench for buzzer_note_sequencer: note queue playback against a predictor
module tb;
    import bns_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP      = 2'd3;
    localparam int              CYCLE_LIMIT = 400_000;

    class playback_scoreboard;
        logic [FREQ_W+MS_W-1:0] notes [BNS_QUEUE_DEPTH];
        int unsigned            queue_len;
        int unsigned            play_pos;
        bit                     slot_active;
        logic [MS_W-1:0]        elapsed;
        logic [FREQ_W-1:0]      freq_now;
        logic [DUTY_W-1:0]      duty_now;
        logic [VOL_W-1:0]       level;
        res_t                   expected_states [$];
        int                     errors;

        function new();
            queue_len   = 0;
            play_pos    = 0;
            slot_active = 1'b0;
            elapsed     = '0;
            freq_now    = '0;
            duty_now    = DUTY_OFF;
            level       = VOL_RESET;
            errors      = 0;
        endfunction

        function void set_level(logic [VOL_W-1:0] v);
            level = v;
        endfunction

        function int pending();
            return expected_states.size();
        endfunction

        // one millisecond of playback
        function void advance_ms();
            logic [FREQ_W+MS_W-1:0] entry;
            if (elapsed != ELAPSED_MAX)
                elapsed++;
            if (play_pos >= queue_len) begin
                if (slot_active) begin
                    duty_now    = DUTY_OFF;
                    slot_active = 1'b0;
                end
                return;
            end
            entry = notes[play_pos];
            if (!slot_active || elapsed >= entry[FREQ_W +: MS_W]) begin
                if (slot_active) begin
                    play_pos++;
                    duty_now = DUTY_OFF;
                end
                if (play_pos >= queue_len)
                    return;
                // note finished with more queued: one silent tick first
                if (slot_active) begin
                    elapsed     = '0;
                    slot_active = 1'b0;
                    return;
                end
                entry = notes[play_pos];
                if (entry[FREQ_W-1:0] != '0) begin
                    freq_now = entry[FREQ_W-1:0];
                    duty_now = (level == VOL_QUIET) ? DUTY_QUIET : DUTY_LOUD;
                end
                elapsed     = '0;
                slot_active = 1'b1;
            end
        endfunction

        function void accept_op(logic [OP_W-1:0] op, logic [FREQ_W-1:0] freq,
                                logic [MS_W-1:0] ms);
            res_t state;
            case (op)
                OP_TICK: advance_ms();
                OP_ADD:
                    if (queue_len < BNS_QUEUE_DEPTH) begin
                        notes[queue_len] = {ms, freq};
                        queue_len++;
                    end
                OP_CLEAR: begin
                    queue_len   = 0;
                    play_pos    = 0;
                    slot_active = 1'b0;
                    duty_now    = DUTY_OFF;
                end
                default: ;
            endcase
            state.tone_freq = freq_now;
            state.duty      = duty_now;
            state.busy_res  = (play_pos < queue_len);
            state.sounding  = slot_active;
            expected_states.push_back(state);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_states.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_states.pop_front();
            check_field("tone_freq", want.tone_freq, got.tone_freq);
            check_field("duty", want.duty, got.duty);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("sounding", want.sounding, got.sounding);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bns_in_if  note_in ();
    bns_out_if note_out ();
    bns_cfg_if cfg ();

    buzzer_note_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .note_in  (note_in),
        .note_out (note_out),
        .cfg      (cfg)
    );

    playback_scoreboard board;
    bit                 valid_up;
    bit                 gaps_on;
    bit                 rx_always;
    int                 burst_left;
    int                 items_sent;
    int                 cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: free-running, random, or one transfer in four
    initial
    begin
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        note_out.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_always) begin
                note_out.ready <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(8, 48);
                end
                rx_left--;
                case (rx_mode)
                    0:       note_out.ready <= 1'b1;
                    1:       note_out.ready <= 1'($urandom_range(0, 1));
                    default: note_out.ready <= (rx_left % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && note_out.valid === 1'b1 && note_out.ready === 1'b1) begin
            got.tone_freq = note_out.tone_freq;
            got.duty      = note_out.duty;
            got.busy_res  = note_out.busy_res;
            got.sounding  = note_out.sounding;
            board.check_result(got);
        end
    end

    function automatic logic [MS_W-1:0] rand_ms();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 16)
            return MS_W'($urandom_range(0, 4));
        else if (pick < 19)
            return MS_W'($urandom_range(5, 20));
        return MS_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return FREQ_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] freq,
                           input logic [MS_W-1:0] ms);
        note_in.valid     <= 1'b1;
        note_in.operation <= op;
        note_in.note_freq <= freq;
        note_in.note_ms   <= ms;
        valid_up = 1'b1;
        do @(posedge clk); while (note_in.ready !== 1'b1);
        board.accept_op(op, freq, ms);
        if (op != OP_NOP)
            items_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                note_in.valid <= 1'b0;
                valid_up = 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_tick();
        send_op(OP_TICK, FREQ_W'($urandom_range(0, 65535)), MS_W'($urandom_range(0, 65535)));
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        if (valid_up) begin
            note_in.valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_level(input logic [VOL_W-1:0] v);
        drain();
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        board.set_level(v);
    endtask

    task automatic play_melody();
        int               n;
        int               span;
        logic [MS_W-1:0]  m;
        n    = $urandom_range(1, 5);
        span = 0;
        repeat (n) begin
            m = rand_ms();
            span += (m > 60) ? 60 : m + 2;
            send_op(OP_ADD, rand_freq(), m);
        end
        repeat ($urandom_range(1, (span > 60) ? 60 : span + 2)) begin
            // occasional append while playing or just after the queue drains
            if ($urandom_range(0, 15) == 0)
                send_op(OP_ADD, rand_freq(), rand_ms());
            else
                send_tick();
        end
    endtask

    task automatic run_random(input int target);
        int kind;
        items_sent = 0;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0)
                gaps_on = !gaps_on;
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                play_melody();
            end else if (kind == 6) begin
                send_op(OP_CLEAR, FREQ_W'($urandom_range(0, 65535)),
                        MS_W'($urandom_range(0, 65535)));
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 4))
                    send_op(OP_W'($urandom_range(0, 3)), FREQ_W'($urandom_range(0, 65535)),
                            MS_W'($urandom_range(0, 65535)));
            end else if (kind == 8) begin
                drain();
            end else begin
                repeat ($urandom_range(1, 10)) send_tick();
            end
        end
    endtask

    initial
    begin
        board      = new();
        valid_up   = 1'b0;
        gaps_on    = 1'b1;
        rx_always  = 1'b0;
        burst_left = 0;
        items_sent = 0;
        cycle_count <= 0;
        rst_n <= 1'b0;
        note_in.valid     <= 1'b0;
        note_in.operation <= OP_TICK;
        note_in.note_freq <= '0;
        note_in.note_ms   <= '0;
        cfg.valid <= 1'b0;
        cfg.data  <= VOL_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at the reset volume
        send_op(OP_TICK, '0, '0);
        send_op(OP_CLEAR, 16'hFFFF, 16'hFFFF);
        send_op(OP_NOP, 16'hFFFF, '0);
        send_op(OP_ADD, 16'hFFFF, 16'h0000);
        send_op(OP_ADD, 16'h0000, 16'd2);
        send_op(OP_TICK, '0, '0);
        send_op(OP_TICK, '0, '0);
        send_op(OP_TICK, '0, '0);
        send_op(OP_TICK, '0, '0);
        send_op(OP_TICK, '0, '0);
        // append after drain: the still-open slot is timed against the new note
        send_op(OP_ADD, 16'h0001, 16'd1);
        send_op(OP_TICK, 16'hFFFF, 16'hFFFF);
        send_op(OP_TICK, '0, '0);
        send_op(OP_ADD, 16'h8000, 16'hFFFF);
        send_op(OP_TICK, '0, '0);
        send_op(OP_NOP, '0, 16'hFFFF);
        send_op(OP_ADD, 16'h5555, 16'h00AA);
        send_op(OP_TICK, '0, '0);
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_TICK, '0, '0);

        write_level(VOL_QUIET);
        run_random(150);

        // fill past capacity, then play a while; the last adds are dropped
        write_level(2'd0);
        send_op(OP_CLEAR, '0, '0);
        repeat (BNS_QUEUE_DEPTH + 2) send_op(OP_ADD, rand_freq(), MS_W'($urandom_range(0, 2)));
        repeat (40) send_tick();
        send_op(OP_ADD, 16'h1234, 16'd1);
        repeat (4) send_tick();
        send_op(OP_CLEAR, '0, '0);

        // longest note held open, then an append while it still plays
        write_level(2'd3);
        gaps_on   = 1'b0;
        rx_always = 1'b1;
        send_op(OP_ADD, 16'd440, 16'hFFFF);
        repeat (40) send_tick();
        send_op(OP_ADD, 16'd880, 16'hFFFF);
        repeat (3) send_tick();
        send_op(OP_CLEAR, '0, '0);
        drain();
        rx_always = 1'b0;
        gaps_on   = 1'b1;

        write_level(VOL_RESET);
        run_random(150);
        write_level(2'd0);
        run_random(150);
        write_level(VOL_QUIET);
        run_random(150);

        drain();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
